// ===== src/gbwo_pkg.sv =====
package gbwo_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAME_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SCREEN_HEIGHT = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SLIDE_MODE    = 3'd2,
    REG_FRAME_TOTAL   = 3'd3,
    REG_OLD_ORIGIN_X  = 3'd4,
    REG_OLD_ORIGIN_Y  = 3'd5,
    REG_NEW_ORIGIN_X  = 3'd6,
    REG_NEW_ORIGIN_Y  = 3'd7
  } cfg_reg_t;

  localparam int SCREEN_HEIGHT_RST = 480;
  localparam int SCREEN_WIDTH_RST  = 640;
  localparam int FRAME_TOTAL_RST   = 60;

  localparam logic SLIDE_NEW_FALLS   = 1'b0;
  localparam logic SLIDE_OLD_COVERED = 1'b1;

endpackage

// ===== src/gbwo_cfg.sv =====
module gbwo_cfg #(
  parameter int COORD_BITS = gbwo_pkg::COORD_BITS_DEF,
  parameter int FRAME_BITS = gbwo_pkg::FRAME_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [gbwo_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS)-1:0] cfg_wdata,
  output logic [COORD_BITS-1:0]                  screen_height,
  output logic [COORD_BITS-1:0]                  screen_width,
  output logic                                   slide_mode,
  output logic [FRAME_BITS-1:0]                  frame_total,
  output logic [COORD_BITS-1:0]                  old_origin_x,
  output logic [COORD_BITS-1:0]                  old_origin_y,
  output logic [COORD_BITS-1:0]                  new_origin_x,
  output logic [COORD_BITS-1:0]                  new_origin_y
);
  import gbwo_pkg::*;

  logic [COORD_BITS-1:0] screen_height_r;
  logic [COORD_BITS-1:0] screen_width_r;
  logic                  slide_mode_r;
  logic [FRAME_BITS-1:0] frame_total_r;
  logic [COORD_BITS-1:0] old_origin_x_r;
  logic [COORD_BITS-1:0] old_origin_y_r;
  logic [COORD_BITS-1:0] new_origin_x_r;
  logic [COORD_BITS-1:0] new_origin_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_height_r <= COORD_BITS'(SCREEN_HEIGHT_RST);
      screen_width_r  <= COORD_BITS'(SCREEN_WIDTH_RST);
      slide_mode_r    <= SLIDE_NEW_FALLS;
      frame_total_r   <= FRAME_BITS'(FRAME_TOTAL_RST);
      old_origin_x_r  <= '0;
      old_origin_y_r  <= '0;
      new_origin_x_r  <= '0;
      new_origin_y_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata[COORD_BITS-1:0];
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_SLIDE_MODE:    slide_mode_r    <= cfg_wdata[0];
        REG_FRAME_TOTAL:   frame_total_r   <= cfg_wdata[FRAME_BITS-1:0];
        REG_OLD_ORIGIN_X:  old_origin_x_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_OLD_ORIGIN_Y:  old_origin_y_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_NEW_ORIGIN_X:  new_origin_x_r  <= cfg_wdata[COORD_BITS-1:0];
        REG_NEW_ORIGIN_Y:  new_origin_y_r  <= cfg_wdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign screen_height = screen_height_r;
  assign screen_width  = screen_width_r;
  assign slide_mode    = slide_mode_r;
  assign frame_total   = frame_total_r;
  assign old_origin_x  = old_origin_x_r;
  assign old_origin_y  = old_origin_y_r;
  assign new_origin_x  = new_origin_x_r;
  assign new_origin_y  = new_origin_y_r;

endmodule

// ===== src/gbwo_front.sv =====
module gbwo_front #(
  parameter int COORD_BITS = gbwo_pkg::COORD_BITS_DEF,
  parameter int FRAME_BITS = gbwo_pkg::FRAME_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  logic [FRAME_BITS-1:0]                   in_frame,
  input  logic [FRAME_BITS-1:0]                   frame_total,
  input  logic [COORD_BITS-1:0]                   screen_height,
  output logic                                    out_valid,
  output logic [COORD_BITS+2*FRAME_BITS+4:0]      out_num,
  output logic [2*FRAME_BITS+4:0]                 out_den
);

  localparam int TW      = FRAME_BITS;
  localparam int SW      = 2 * TW;
  localparam int DW      = SW + 4;
  localparam int NW      = COORD_BITS + SW;
  localparam int XW      = NW + 5;
  localparam int YW      = DW + 1;
  localparam int XT      = FRAME_BITS + 4;
  localparam int DIVISOR = 17;
  localparam logic [XT-1:0] RECIP = XT'((64'd1 << XT) / 64'(DIVISOR));

  typedef enum logic [1:0] {
    PH_FALL    = 2'd0,
    PH_BOUNCE1 = 2'd1,
    PH_BOUNCE2 = 2'd2,
    PH_REST    = 2'd3
  } phase_t;

  // stage 1: reciprocal estimates of 9T/17 and 6T/17
  logic [XT-1:0]   x9, x6;
  logic [2*XT-1:0] prod9, prod6;
  logic            v1_r;
  logic [TW-1:0]   c1_r;
  logic [XT-1:0]   e9_r, e6_r;

  assign x9    = (XT'(frame_total) << 3) + XT'(frame_total);
  assign x6    = (XT'(frame_total) << 2) + (XT'(frame_total) << 1);
  assign prod9 = (2*XT)'(x9) * (2*XT)'(RECIP);
  assign prod6 = (2*XT)'(x6) * (2*XT)'(RECIP);

  always_ff @(posedge clk) begin
    c1_r <= in_frame;
    e9_r <= prod9[2*XT-1:XT];
    e6_r <= prod6[2*XT-1:XT];
  end

  // stage 2: quotient correction, phase lengths
  logic [XT-1:0] r9, r6, q9, q6;
  logic [TW-1:0] t1_nxt, t2_nxt;
  logic          v2_r;
  logic [TW-1:0] c2_r, t1_2_r, t2_2_r;

  always_comb begin
    r9 = x9 - ((e9_r << 4) + e9_r);
    r6 = x6 - ((e6_r << 4) + e6_r);
    q9 = e9_r + XT'(r9 >= XT'(DIVISOR));
    q6 = e6_r + XT'(r6 >= XT'(DIVISOR));
    t1_nxt = (q9 == '0) ? TW'(1) : q9[TW-1:0];
    t2_nxt = (q6 == '0) ? TW'(1) : q6[TW-1:0];
  end

  always_ff @(posedge clk) begin
    c2_r   <= c1_r;
    t1_2_r <= t1_nxt;
    t2_2_r <= t2_nxt;
  end

  // stage 3: phase select and time within phase
  logic [TW:0]   s12, tot, end_f, cz;
  phase_t        ph_nxt;
  logic [TW-1:0] tt_nxt;
  logic          v3_r;
  phase_t        ph3_r;
  logic [TW-1:0] tt3_r, t1_3_r;

  always_comb begin
    s12   = (TW+1)'(t1_2_r) + (TW+1)'(t2_2_r);
    tot   = (TW+1)'(frame_total);
    end_f = (tot > s12) ? tot : s12;
    cz    = (TW+1)'(c2_r);
    if (cz < (TW+1)'(t1_2_r)) begin
      ph_nxt = PH_FALL;
      tt_nxt = c2_r;
    end else if (cz < s12) begin
      ph_nxt = PH_BOUNCE1;
      tt_nxt = TW'(cz - (TW+1)'(t1_2_r));
    end else if (cz < end_f) begin
      ph_nxt = PH_BOUNCE2;
      tt_nxt = TW'(cz - s12);
    end else begin
      ph_nxt = PH_REST;
      tt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    ph3_r  <= ph_nxt;
    tt3_r  <= tt_nxt;
    t1_3_r <= t1_2_r;
  end

  // stage 4: squares and cross product
  logic [TW+3:0] tt3x, tt9x, lim;
  logic          kill_nxt;
  logic          v4_r;
  phase_t        ph4_r;
  logic          kill4_r;
  logic [SW-1:0] sq4_r, ts4_r, cr4_r;

  always_comb begin
    tt3x = ((TW+4)'(tt3_r) << 1) + (TW+4)'(tt3_r);
    tt9x = ((TW+4)'(tt3_r) << 3) + (TW+4)'(tt3_r);
    lim  = (TW+4)'(t1_3_r) << 1;
    unique case (ph3_r)
      PH_FALL:    kill_nxt = 1'b0;
      PH_BOUNCE1: kill_nxt = (tt3x >= lim);
      PH_BOUNCE2: kill_nxt = (tt9x >= lim);
      default:    kill_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    ph4_r   <= ph3_r;
    kill4_r <= kill_nxt;
    sq4_r   <= SW'(t1_3_r) * SW'(t1_3_r);
    ts4_r   <= SW'(tt3_r) * SW'(tt3_r);
    cr4_r   <= SW'(t1_3_r) * SW'(tt3_r);
  end

  // stage 5: numerator polynomial and denominator
  logic [DW-1:0] sqw, tsw, crw, pw, dw;
  logic          v5_r;
  logic [SW-1:0] p5_r;
  logic [DW-1:0] d5_r;

  always_comb begin
    sqw = DW'(sq4_r);
    tsw = DW'(ts4_r);
    crw = DW'(cr4_r);
    unique case (ph4_r)
      PH_FALL: begin
        pw = sqw - tsw;
        dw = sqw;
      end
      PH_BOUNCE1: begin
        pw = (crw << 1) - ((tsw << 1) + tsw);
        dw = (sqw << 1) + sqw;
      end
      PH_BOUNCE2: begin
        pw = (crw << 1) - ((tsw << 3) + tsw);
        dw = (sqw << 3) + sqw;
      end
      default: begin
        pw = '0;
        dw = sqw;
      end
    endcase
    if (kill4_r) begin
      pw = '0;
    end
  end

  always_ff @(posedge clk) begin
    p5_r <= pw[SW-1:0];
    d5_r <= dw;
  end

  // stage 6: height times numerator as two partial products
  logic                 v6_r;
  logic [COORD_BITS+TW-1:0] pl6_r, ph6_r;
  logic [DW-1:0]        d6_r;

  always_ff @(posedge clk) begin
    pl6_r <= (COORD_BITS+TW)'(screen_height) * (COORD_BITS+TW)'(p5_r[TW-1:0]);
    ph6_r <= (COORD_BITS+TW)'(screen_height) * (COORD_BITS+TW)'(p5_r[SW-1:TW]);
    d6_r  <= d5_r;
  end

  // stage 7: dividend 2N+D and divisor 2D for round half up
  logic [NW-1:0] n_sum;
  logic          v7_r;
  logic [XW-1:0] x7_r;
  logic [YW-1:0] y7_r;

  assign n_sum = (NW'(ph6_r) << TW) + NW'(pl6_r);

  always_ff @(posedge clk) begin
    x7_r <= (XW'(n_sum) << 1) + XW'(d6_r);
    y7_r <= YW'(d6_r) << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  assign out_valid = v7_r;
  assign out_num   = x7_r;
  assign out_den   = y7_r;

endmodule

// ===== src/gbwo_div.sv =====
module gbwo_div #(
  parameter int COORD_BITS = gbwo_pkg::COORD_BITS_DEF,
  parameter int FRAME_BITS = gbwo_pkg::FRAME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [COORD_BITS+2*FRAME_BITS+4:0] in_num,
  input  logic [2*FRAME_BITS+4:0]            in_den,
  output logic                               out_valid,
  output logic [COORD_BITS-1:0]              out_quot
);

  localparam int XW = COORD_BITS + 2 * FRAME_BITS + 5;
  localparam int YW = 2 * FRAME_BITS + 5;
  localparam int QB = COORD_BITS;

  // one restoring step per stage, quotient msb first
  logic [XW-1:0] rem_in   [QB];
  logic [YW-1:0] den_in   [QB];
  logic [QB-1:0] q_in     [QB];
  logic [XW-1:0] shifted  [QB];
  logic [XW-1:0] rem_nxt  [QB];
  logic [QB-1:0] q_nxt    [QB];
  logic [XW-1:0] rem_r    [QB];
  logic [YW-1:0] den_r    [QB];
  logic [QB-1:0] q_r      [QB];
  logic [QB-1:0] v_r;

  always_comb begin
    for (int s = 0; s < QB; s++) begin
      if (s == 0) begin
        rem_in[s] = in_num;
        den_in[s] = in_den;
        q_in[s]   = '0;
      end else begin
        rem_in[s] = rem_r[s-1];
        den_in[s] = den_r[s-1];
        q_in[s]   = q_r[s-1];
      end
      shifted[s] = XW'(den_in[s]) << (QB - 1 - s);
      if (rem_in[s] >= shifted[s]) begin
        rem_nxt[s] = rem_in[s] - shifted[s];
        q_nxt[s]   = {q_in[s][QB-2:0], 1'b1};
      end else begin
        rem_nxt[s] = rem_in[s];
        q_nxt[s]   = {q_in[s][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < QB; s++) begin
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_in[s];
      q_r[s]   <= q_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[QB-2:0], in_valid};
    end
  end

  assign out_valid = v_r[QB-1];
  assign out_quot  = q_r[QB-1];

endmodule

// ===== src/gravity_bounce_wipe_offset_core.sv =====
// a start transfer passes the front pipeline, the restoring divider and the output register before out_valid
// throughput: one frame index per cycle; busy stays low, every stage advances each cycle
// the rate is set by the fully pipelined restoring divider, one quotient bit per stage
// synchronous reset (rst_n low) loads the register defaults and clears all stage valids
// results are shown for one cycle only, the receiver cannot stall
module gravity_bounce_wipe_offset_core #(
  parameter int COORD_BITS = gbwo_pkg::COORD_BITS_DEF,
  parameter int FRAME_BITS = gbwo_pkg::FRAME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [FRAME_BITS-1:0]               in_frame_index,
  input  logic                                cfg_we,
  input  logic [gbwo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [((COORD_BITS > FRAME_BITS) ? COORD_BITS : FRAME_BITS)-1:0] cfg_wdata,
  output logic                                out_valid,
  output logic [COORD_BITS-1:0]               out_drop_offset,
  output logic [COORD_BITS-1:0]               out_old_put_y,
  output logic [COORD_BITS-1:0]               out_old_src_x,
  output logic [COORD_BITS:0]                 out_old_src_y,
  output logic [COORD_BITS-1:0]               out_old_height,
  output logic                                out_old_draw,
  output logic signed [COORD_BITS:0]          out_new_put_y,
  output logic [COORD_BITS-1:0]               out_new_src_x,
  output logic [COORD_BITS-1:0]               out_new_src_y,
  output logic [COORD_BITS-1:0]               out_new_height,
  output logic                                out_new_draw,
  output logic [COORD_BITS-1:0]               out_copy_width
);
  import gbwo_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB-1:0]         screen_height, screen_width;
  logic                  slide_mode;
  logic [FRAME_BITS-1:0] frame_total;
  logic [CB-1:0]         old_origin_x, old_origin_y, new_origin_x, new_origin_y;

  logic                           fr_valid;
  logic [CB+2*FRAME_BITS+4:0]     fr_num;
  logic [2*FRAME_BITS+4:0]        fr_den;
  logic                           dv_valid;
  logic [CB-1:0]                  dv_quot;

  gbwo_cfg #(
    .COORD_BITS(COORD_BITS),
    .FRAME_BITS(FRAME_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .screen_height(screen_height),
    .screen_width (screen_width),
    .slide_mode   (slide_mode),
    .frame_total  (frame_total),
    .old_origin_x (old_origin_x),
    .old_origin_y (old_origin_y),
    .new_origin_x (new_origin_x),
    .new_origin_y (new_origin_y)
  );

  assign busy = 1'b0;

  gbwo_front #(
    .COORD_BITS(COORD_BITS),
    .FRAME_BITS(FRAME_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (start & ~busy),
    .in_frame     (in_frame_index),
    .frame_total  (frame_total),
    .screen_height(screen_height),
    .out_valid    (fr_valid),
    .out_num      (fr_num),
    .out_den      (fr_den)
  );

  gbwo_div #(
    .COORD_BITS(COORD_BITS),
    .FRAME_BITS(FRAME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fr_valid),
    .in_num   (fr_num),
    .in_den   (fr_den),
    .out_valid(dv_valid),
    .out_quot (dv_quot)
  );

  // output stage: blit rectangles from the offset
  logic [CB-1:0] d, rest, old_h, new_h;
  logic [CB:0]   old_sy, new_py;

  logic          out_valid_r;
  logic [CB-1:0] out_drop_offset_r, out_old_put_y_r, out_old_src_x_r, out_old_height_r;
  logic [CB:0]   out_old_src_y_r, out_new_put_y_r;
  logic          out_old_draw_r, out_new_draw_r;
  logic [CB-1:0] out_new_src_x_r, out_new_src_y_r, out_new_height_r, out_copy_width_r;

  always_comb begin
    d    = (dv_quot > screen_height) ? screen_height : dv_quot;
    rest = screen_height - d;
    if (slide_mode == SLIDE_NEW_FALLS) begin
      old_sy = (CB+1)'(rest) + (CB+1)'(old_origin_y);
      old_h  = d;
      new_py = (CB+1)'(0) - (CB+1)'(d);
      new_h  = screen_height;
    end else begin
      old_sy = (CB+1)'(old_origin_y);
      old_h  = screen_height;
      new_py = '0;
      new_h  = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_drop_offset_r <= d;
    out_old_put_y_r   <= rest;
    out_old_src_x_r   <= old_origin_x;
    out_old_src_y_r   <= old_sy;
    out_old_height_r  <= old_h;
    out_old_draw_r    <= (screen_width != '0) && (old_h != '0);
    out_new_put_y_r   <= new_py;
    out_new_src_x_r   <= new_origin_x;
    out_new_src_y_r   <= new_origin_y;
    out_new_height_r  <= new_h;
    out_new_draw_r    <= (screen_width != '0) && (new_h != '0);
    out_copy_width_r  <= screen_width;
  end

  assign out_valid       = out_valid_r;
  assign out_drop_offset = out_drop_offset_r;
  assign out_old_put_y   = out_old_put_y_r;
  assign out_old_src_x   = out_old_src_x_r;
  assign out_old_src_y   = out_old_src_y_r;
  assign out_old_height  = out_old_height_r;
  assign out_old_draw    = out_old_draw_r;
  assign out_new_put_y   = signed'(out_new_put_y_r);
  assign out_new_src_x   = out_new_src_x_r;
  assign out_new_src_y   = out_new_src_y_r;
  assign out_new_height  = out_new_height_r;
  assign out_new_draw    = out_new_draw_r;
  assign out_copy_width  = out_copy_width_r;

endmodule

// ===== tb/gravity_bounce_wipe_offset_checker.sv =====
module gravity_bounce_wipe_offset_checker #(
  parameter int CB = gbwo_pkg::COORD_BITS_DEF,
  parameter int FB = gbwo_pkg::FRAME_BITS_DEF,
  parameter int WB = (CB > FB) ? CB : FB
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [FB-1:0]                       frame_index,
  input  logic                                cfg_we,
  input  logic [gbwo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WB-1:0]                       cfg_wdata,
  input  logic                                out_valid,
  input  logic [CB-1:0]                       drop_offset,
  input  logic [CB-1:0]                       old_put_y,
  input  logic [CB-1:0]                       old_src_x,
  input  logic [CB:0]                         old_src_y,
  input  logic [CB-1:0]                       old_height,
  input  logic                                old_draw,
  input  logic signed [CB:0]                  new_put_y,
  input  logic [CB-1:0]                       new_src_x,
  input  logic [CB-1:0]                       new_src_y,
  input  logic [CB-1:0]                       new_height,
  input  logic                                new_draw,
  input  logic [CB-1:0]                       copy_width,
  output int                                  error_count,
  output int                                  outstanding
);
  import gbwo_pkg::*;

  typedef struct packed {
    logic [CB-1:0] drop_offset;
    logic [CB-1:0] old_put_y;
    logic [CB-1:0] old_src_x;
    logic [CB:0]   old_src_y;
    logic [CB-1:0] old_height;
    logic          old_draw;
    logic [CB:0]   new_put_y;
    logic [CB-1:0] new_src_x;
    logic [CB-1:0] new_src_y;
    logic [CB-1:0] new_height;
    logic          new_draw;
    logic [CB-1:0] copy_width;
  } wipe_rect_t;

  logic [CB-1:0] height_r;
  logic [CB-1:0] width_r;
  logic          mode_r;
  logic [FB-1:0] total_r;
  logic [CB-1:0] old_x_r;
  logic [CB-1:0] old_y_r;
  logic [CB-1:0] new_x_r;
  logic [CB-1:0] new_y_r;

  wipe_rect_t pending_rects [$];
  wipe_rect_t due;

  // half-up rounded drop distance for frame c, clamped to [0, height]
  function automatic logic [CB-1:0] fall_offset(input logic [FB-1:0] c);
    longint unsigned h, tt, t1, t2, t3, t, cc, num, den, d;
    h = height_r;
    tt = total_r;
    cc = c;
    t1 = (tt * 9) / 17;
    t2 = (tt * 6) / 17;
    if (t1 < 1) t1 = 1;
    if (t2 < 1) t2 = 1;
    t3 = (tt > t1 + t2) ? tt - t1 - t2 : 0;
    d = 0;
    if (cc < t1) begin
      num = h * (t1 * t1 - cc * cc);
      den = t1 * t1;
      d = (2 * num + den) / (2 * den);
    end else if (cc < t1 + t2) begin
      t = cc - t1;
      if (3 * t < 2 * t1) begin
        num = h * (2 * t1 * t - 3 * t * t);
        den = 3 * t1 * t1;
        d = (2 * num + den) / (2 * den);
      end
    end else if (cc < t1 + t2 + t3) begin
      t = cc - t1 - t2;
      if (9 * t < 2 * t1) begin
        num = h * (2 * t1 * t - 9 * t * t);
        den = 9 * t1 * t1;
        d = (2 * num + den) / (2 * den);
      end
    end
    if (d > h) d = h;
    return CB'(d);
  endfunction

  function automatic wipe_rect_t predict_wipe(input logic [FB-1:0] c);
    wipe_rect_t r;
    logic [CB-1:0] d;
    d = fall_offset(c);
    r.drop_offset = d;
    r.old_put_y   = height_r - d;
    r.old_src_x   = old_x_r;
    r.new_src_x   = new_x_r;
    r.new_src_y   = new_y_r;
    r.copy_width  = width_r;
    if (mode_r == SLIDE_NEW_FALLS) begin
      r.old_src_y  = {1'b0, height_r - d} + {1'b0, old_y_r};
      r.old_height = d;
      r.new_put_y  = -{1'b0, d};
      r.new_height = height_r;
    end else begin
      r.old_src_y  = {1'b0, old_y_r};
      r.old_height = height_r;
      r.new_put_y  = '0;
      r.new_height = height_r - d;
    end
    r.old_draw = (width_r != '0) && (r.old_height != '0);
    r.new_draw = (width_r != '0) && (r.new_height != '0);
    return r;
  endfunction

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      height_r = CB'(SCREEN_HEIGHT_RST);
      width_r  = CB'(SCREEN_WIDTH_RST);
      mode_r   = SLIDE_NEW_FALLS;
      total_r  = FB'(FRAME_TOTAL_RST);
      old_x_r  = '0;
      old_y_r  = '0;
      new_x_r  = '0;
      new_y_r  = '0;
      pending_rects.delete();
      error_count = 0;
      outstanding <= 0;
    end else begin
      if (start && !busy) pending_rects.push_back(predict_wipe(frame_index));
      if (out_valid) begin
        if (pending_rects.size() == 0) begin
          $error("out_valid with no frame transfer pending");
          error_count++;
        end else begin
          due = pending_rects.pop_front();
          compare_field("drop_offset", due.drop_offset, drop_offset);
          compare_field("old_put_y", due.old_put_y, old_put_y);
          compare_field("old_src_x", due.old_src_x, old_src_x);
          compare_field("old_src_y", due.old_src_y, old_src_y);
          compare_field("old_height", due.old_height, old_height);
          compare_field("old_draw", due.old_draw, old_draw);
          compare_field("new_put_y", $signed(due.new_put_y), new_put_y);
          compare_field("new_src_x", due.new_src_x, new_src_x);
          compare_field("new_src_y", due.new_src_y, new_src_y);
          compare_field("new_height", due.new_height, new_height);
          compare_field("new_draw", due.new_draw, new_draw);
          compare_field("copy_width", due.copy_width, copy_width);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SCREEN_HEIGHT: height_r = cfg_wdata[CB-1:0];
          REG_SCREEN_WIDTH:  width_r  = cfg_wdata[CB-1:0];
          REG_SLIDE_MODE:    mode_r   = cfg_wdata[0];
          REG_FRAME_TOTAL:   total_r  = cfg_wdata[FB-1:0];
          REG_OLD_ORIGIN_X:  old_x_r  = cfg_wdata[CB-1:0];
          REG_OLD_ORIGIN_Y:  old_y_r  = cfg_wdata[CB-1:0];
          REG_NEW_ORIGIN_X:  new_x_r  = cfg_wdata[CB-1:0];
          REG_NEW_ORIGIN_Y:  new_y_r  = cfg_wdata[CB-1:0];
          default: ;
        endcase
      end
      outstanding <= pending_rects.size();
    end
  end

endmodule

// ===== tb/tb_gravity_bounce_wipe_offset_core.sv =====
module tb_gravity_bounce_wipe_offset_core;
  import gbwo_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = FRAME_BITS_DEF;
  localparam int WB = (CB > FB) ? CB : FB;
  localparam int PHASES = 18;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [FB-1:0]             in_frame_index = '0;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [WB-1:0]             cfg_wdata = '0;
  logic                      out_valid;
  logic [CB-1:0]             out_drop_offset;
  logic [CB-1:0]             out_old_put_y;
  logic [CB-1:0]             out_old_src_x;
  logic [CB:0]               out_old_src_y;
  logic [CB-1:0]             out_old_height;
  logic                      out_old_draw;
  logic signed [CB:0]        out_new_put_y;
  logic [CB-1:0]             out_new_src_x;
  logic [CB-1:0]             out_new_src_y;
  logic [CB-1:0]             out_new_height;
  logic                      out_new_draw;
  logic [CB-1:0]             out_copy_width;

  int error_count;
  int outstanding;
  int idle_pct = 0;
  bit quiet_tail = 1'b0;
  logic [WB-1:0] setting [8];

  logic [FB-1:0] opening_frames [17] = '{
    16'd0, 16'd1, 16'd15, 16'd30, 16'd31, 16'd32, 16'd41, 16'd51, 16'd52,
    16'd53, 16'd59, 16'd60, 16'd61, 16'hFFFF, 16'h8000, 16'h5555, 16'hAAAA
  };

  always #5 clk = ~clk;

  gravity_bounce_wipe_offset_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_frame_index  (in_frame_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_drop_offset (out_drop_offset),
    .out_old_put_y   (out_old_put_y),
    .out_old_src_x   (out_old_src_x),
    .out_old_src_y   (out_old_src_y),
    .out_old_height  (out_old_height),
    .out_old_draw    (out_old_draw),
    .out_new_put_y   (out_new_put_y),
    .out_new_src_x   (out_new_src_x),
    .out_new_src_y   (out_new_src_y),
    .out_new_height  (out_new_height),
    .out_new_draw    (out_new_draw),
    .out_copy_width  (out_copy_width)
  );

  gravity_bounce_wipe_offset_checker #(.CB(CB), .FB(FB), .WB(WB)) wipe_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .frame_index (in_frame_index),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_valid   (out_valid),
    .drop_offset (out_drop_offset),
    .old_put_y   (out_old_put_y),
    .old_src_x   (out_old_src_x),
    .old_src_y   (out_old_src_y),
    .old_height  (out_old_height),
    .old_draw    (out_old_draw),
    .new_put_y   (out_new_put_y),
    .new_src_x   (out_new_src_x),
    .new_src_y   (out_new_src_y),
    .new_height  (out_new_height),
    .new_draw    (out_new_draw),
    .copy_width  (out_copy_width),
    .error_count (error_count),
    .outstanding (outstanding)
  );

  initial begin
    #2000000;
    $display("tb_gravity_bounce_wipe_offset_core: done, errors");
    $finish;
  end

  task automatic send_frame(input logic [FB-1:0] fi);
    if (!quiet_tail && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    start <= 1'b1;
    in_frame_index <= fi;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_setting();
    cfg_reg_t r;
    r = r.first();
    repeat (r.num()) begin
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= setting[r];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  // frames biased toward phase boundaries and the end of the transition
  function automatic logic [FB-1:0] pick_frame(input int unsigned tt);
    int unsigned a, b, e;
    a = (tt * 9) / 17;
    b = (tt * 6) / 17;
    if (a < 1) a = 1;
    if (b < 1) b = 1;
    e = (tt > a + b) ? tt : a + b;
    case ($urandom_range(9))
      0: return FB'(a - 1 + $urandom_range(2));
      1: return FB'(a + b - 1 + $urandom_range(2));
      2: return FB'(e - 1 + $urandom_range(2));
      3: return FB'($urandom);
      4: return $urandom_range(1) ? '1 : '0;
      default: return FB'($urandom_range(e + 2));
    endcase
  endfunction

  task automatic pick_setting(input int p);
    setting[REG_SCREEN_HEIGHT] = WB'(($urandom & 16'hF000) | $urandom_range(1, 4095));
    setting[REG_SCREEN_WIDTH]  = WB'(($urandom & 16'hF000) | $urandom_range(1, 4095));
    setting[REG_SLIDE_MODE]    = WB'($urandom);
    setting[REG_FRAME_TOTAL]   = ($urandom_range(7) == 0) ? WB'($urandom_range(65535))
                                                          : WB'($urandom_range(1, 400));
    setting[REG_OLD_ORIGIN_X]  = WB'($urandom);
    setting[REG_OLD_ORIGIN_Y]  = WB'($urandom);
    setting[REG_NEW_ORIGIN_X]  = WB'($urandom);
    setting[REG_NEW_ORIGIN_Y]  = WB'($urandom);
    case (p)
      0, 1: begin
        setting[REG_SCREEN_HEIGHT] = 16'h0FFF;
        setting[REG_SCREEN_WIDTH]  = 16'hFFFF;
        setting[REG_SLIDE_MODE]    = (p == 0) ? WB'(SLIDE_NEW_FALLS) : WB'(SLIDE_OLD_COVERED);
        setting[REG_FRAME_TOTAL]   = 16'hFFFF;
        setting[REG_OLD_ORIGIN_X]  = 16'h0FFF;
        setting[REG_OLD_ORIGIN_Y]  = 16'h0FFF;
        setting[REG_NEW_ORIGIN_X]  = 16'h0FFF;
        setting[REG_NEW_ORIGIN_Y]  = 16'h0FFF;
      end
      2: begin
        // height wraps to zero
        setting[REG_SCREEN_HEIGHT] = 16'h1000;
        setting[REG_SLIDE_MODE]    = WB'(SLIDE_NEW_FALLS);
        setting[REG_FRAME_TOTAL]   = 16'd60;
      end
      3: begin
        // width wraps to zero
        setting[REG_SCREEN_HEIGHT] = 16'd480;
        setting[REG_SCREEN_WIDTH]  = 16'hF000;
        setting[REG_SLIDE_MODE]    = WB'(SLIDE_OLD_COVERED);
        setting[REG_FRAME_TOTAL]   = 16'd60;
      end
      4: begin
        setting[REG_SCREEN_HEIGHT] = 16'd1;
        setting[REG_SCREEN_WIDTH]  = 16'd1;
        setting[REG_SLIDE_MODE]    = WB'(SLIDE_NEW_FALLS);
        setting[REG_FRAME_TOTAL]   = 16'd0;
        setting[REG_OLD_ORIGIN_X]  = '0;
        setting[REG_OLD_ORIGIN_Y]  = '0;
        setting[REG_NEW_ORIGIN_X]  = '0;
        setting[REG_NEW_ORIGIN_Y]  = '0;
      end
      5: begin
        setting[REG_SCREEN_HEIGHT] = 16'h0FFF;
        setting[REG_SLIDE_MODE]    = WB'(SLIDE_OLD_COVERED);
        setting[REG_FRAME_TOTAL]   = 16'd1;
      end
      6: begin
        setting[REG_SLIDE_MODE]    = WB'(SLIDE_NEW_FALLS);
        setting[REG_FRAME_TOTAL]   = 16'd2;
      end
      default: ;
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct = 30;
    foreach (opening_frames[i]) send_frame(opening_frames[i]);
    drain();
    for (int p = 0; p < PHASES; p++) begin
      pick_setting(p);
      load_setting();
      case ($urandom_range(2))
        0: idle_pct = 0;
        1: idle_pct = 15;
        default: idle_pct = 50;
      endcase
      quiet_tail = (p == PHASES - 1);
      repeat ((p < 7) ? 60 : 115) send_frame(pick_frame(32'(setting[REG_FRAME_TOTAL])));
      drain();
    end
    repeat (30) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_gravity_bounce_wipe_offset_core: done, clean");
    end else begin
      $display("tb_gravity_bounce_wipe_offset_core: done, errors");
    end
    $finish;
  end

endmodule
